// ===== rtl/rowu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op word unit package
// Shared widths, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package rowu_pkg;

   localparam int WORD_BITS  = 16;
   localparam int FUNC_BITS  = 8;
   localparam int SHIFT_BITS = 5;
   localparam int IDX_BITS   = 3;
   localparam int CSR_BITS   = 16;

   typedef enum logic [IDX_BITS-1:0] {
      REG_ROP_FUNCTION   = 3'd0,
      REG_SHIFT_AMOUNT   = 3'd1,
      REG_LOAD_DIRECTION = 3'd2,
      REG_PATTERN        = 3'd3,
      REG_RIGHT_MASK     = 3'd4,
      REG_LEFT_MASK      = 3'd5,
      REG_ROW_WIDTH      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  rop_function;
      logic [SHIFT_BITS-1:0] shift_amount;
      logic                  load_direction;
      logic [WORD_BITS-1:0]  pattern;
      logic [WORD_BITS-1:0]  right_mask;
      logic [WORD_BITS-1:0]  left_mask;
      logic [WORD_BITS-1:0]  row_width;
   } cfg_type;

endpackage

// ===== rtl/rowu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op word unit channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface rowu_req_if
   import rowu_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] cpu_word;
   logic [WORD_BITS-1:0] frame_word;

   modport source (output valid, output cpu_word, output frame_word, input ready);
   modport sink   (input valid, input cpu_word, input frame_word, output ready);
endinterface

interface rowu_rsp_if
   import rowu_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result_word;
   logic                 row_end;
   logic [WORD_BITS-1:0] counter_value;

   modport source (output valid, output result_word, output row_end,
                   output counter_value, input ready);
   modport sink   (input valid, input result_word, input row_end,
                   input counter_value, output ready);
endinterface

interface rowu_csr_if
   import rowu_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [IDX_BITS-1:0] index;
   logic [CSR_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rowu_rop_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op word datapath
// Funnel shift of the source pair, per-bit function table and edge masking.
// ----------------------------------------------------------------------------
module rowu_rop_core
   import rowu_pkg::*;
(
   input  cfg_type              cfg,
   input  logic [WORD_BITS-1:0] source_low,
   input  logic [WORD_BITS-1:0] source_high,
   input  logic [WORD_BITS-1:0] frame_word,
   input  logic                 first_word,
   input  logic                 last_word,
   output logic [WORD_BITS-1:0] result_word
);

   logic [SHIFT_BITS-1:0]  shift_sat;
   logic [2*WORD_BITS-1:0] pair_shifted;
   logic [WORD_BITS-1:0]   aligned_src;
   logic [WORD_BITS-1:0]   func_out;
   logic [WORD_BITS-1:0]   keep;

   // Shifts beyond one word saturate, which selects the high slot.
   assign shift_sat = (cfg.shift_amount > SHIFT_BITS'(WORD_BITS)) ?
                      SHIFT_BITS'(WORD_BITS) : cfg.shift_amount;
   assign pair_shifted = {source_high, source_low} >> shift_sat;
   assign aligned_src  = pair_shifted[WORD_BITS-1:0];

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         func_out[i] = cfg.rop_function[{cfg.pattern[i], aligned_src[i], frame_word[i]}];
      end
   end

   assign keep = (first_word ? cfg.left_mask : '0) | (last_word ? cfg.right_mask : '0);
   assign result_word = (func_out & ~keep) | (frame_word & keep);

endmodule

// ===== rtl/raster_op_word_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster-op word unit
// Per-word raster operation with source alignment, edge masks and row count.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word-write request: the processor word and the
//   frame-buffer word from the hidden read. rsp_chan returns the word to
//   write back, a row-end flag and the word counter after the request.
//   csr_chan writes the seven control registers by index; writing the row
//   width also loads the word counter. Unknown indexes are ignored.
// The result is registered and appears in the cycle after the request is
//   accepted. One request per cycle is sustained while the receiver takes
//   each result; the output register is the only stage, and the source pair
//   and counter update as each request is accepted.
// When the receiver stalls, the result holds and req_chan.ready stays high
//   only if the held result is taken in the same cycle.
// Reset clears the control registers, the source pair, the counter and the
//   output valid flag; the output word, row-end flag and count are not reset.
// ----------------------------------------------------------------------------
module raster_op_word_unit_top
   import rowu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   rowu_req_if.sink   req_chan,
   rowu_rsp_if.source rsp_chan,
   rowu_csr_if.sink   csr_chan
);

   cfg_type              cfg_ff, cfg_in;
   logic [WORD_BITS-1:0] src_low_ff, src_low_in;
   logic [WORD_BITS-1:0] src_high_ff, src_high_in;
   logic [WORD_BITS-1:0] counter_ff, counter_in;
   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_word_ff, out_word_in;
   logic                 out_end_ff, out_end_in;
   logic [WORD_BITS-1:0] out_count_ff, out_count_in;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 first_word;
   logic                 last_word;
   logic [WORD_BITS-1:0] rop_word;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   // The new word pushes into the pair from the side the direction selects.
   always_comb begin
      if (cfg_ff.load_direction) begin
         src_high_in = req_fire ? src_low_ff : src_high_ff;
         src_low_in  = req_fire ? req_chan.cpu_word : src_low_ff;
      end else begin
         src_low_in  = req_fire ? src_high_ff : src_low_ff;
         src_high_in = req_fire ? req_chan.cpu_word : src_high_ff;
      end
   end

   assign first_word = (counter_ff == cfg_ff.row_width);
   assign last_word  = (counter_ff == '0);

   rowu_rop_core u_core (
      .cfg         (cfg_ff),
      .source_low  (req_fire ? src_low_in : src_low_ff),
      .source_high (req_fire ? src_high_in : src_high_ff),
      .frame_word  (req_chan.frame_word),
      .first_word  (first_word),
      .last_word   (last_word),
      .result_word (rop_word)
   );

   always_comb begin
      cfg_in     = cfg_ff;
      counter_in = counter_ff;
      if (req_fire) begin
         counter_in = last_word ? cfg_ff.row_width : counter_ff - WORD_BITS'(1);
      end
      if (csr_fire) begin
         case (reg_index_type'(csr_chan.index))
            REG_ROP_FUNCTION:   cfg_in.rop_function   = csr_chan.data[FUNC_BITS-1:0];
            REG_SHIFT_AMOUNT:   cfg_in.shift_amount   = csr_chan.data[SHIFT_BITS-1:0];
            REG_LOAD_DIRECTION: cfg_in.load_direction = csr_chan.data[0];
            REG_PATTERN:        cfg_in.pattern        = csr_chan.data[WORD_BITS-1:0];
            REG_RIGHT_MASK:     cfg_in.right_mask     = csr_chan.data[WORD_BITS-1:0];
            REG_LEFT_MASK:      cfg_in.left_mask      = csr_chan.data[WORD_BITS-1:0];
            REG_ROW_WIDTH: begin
               cfg_in.row_width = csr_chan.data[WORD_BITS-1:0];
               counter_in       = csr_chan.data[WORD_BITS-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_word_in  = out_word_ff;
      out_end_in   = out_end_ff;
      out_count_in = out_count_ff;
      if (req_fire) begin
         out_valid_in = 1'b1;
         out_word_in  = rop_word;
         out_end_in   = last_word;
         out_count_in = last_word ? cfg_ff.row_width : counter_ff - WORD_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         src_low_ff   <= '0;
         src_high_ff  <= '0;
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         src_low_ff   <= src_low_in;
         src_high_ff  <= src_high_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_end_ff   <= out_end_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_word   = out_word_ff;
   assign rsp_chan.row_end       = out_end_ff;
   assign rsp_chan.counter_value = out_count_ff;

endmodule
